/* src/ccgs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccgs_pkg
// shared types and constants for the capped channel grant scheduler
// ----------------------------------------------------------------------------
package ccgs_pkg;

    localparam int unsigned MaxUsersDefault = 8;

    localparam int unsigned ChanW   = 8;
    localparam int unsigned UcntW   = 4;
    localparam int unsigned WtabW   = 64;
    localparam int unsigned UserW   = 3;
    localparam int unsigned QlenW   = 16;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgW    = 64;

    localparam logic       ReqReport   = 1'b0;
    localparam logic       ReqTick     = 1'b1;

    localparam logic [CfgIdxW-1:0] CfgChannelCount = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgUserCount    = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgWeightTable  = 2'd2;

    typedef struct packed {
        logic             req_type;
        logic [UserW-1:0] user_index;
        logic [QlenW-1:0] queue_length;
    } t_in;

    typedef struct packed {
        logic [UserW-1:0] grant_user;
        logic [ChanW-1:0] grant_blocks;
        logic             grant_last;
    } t_out;

    typedef struct packed {
        logic             hit;
        logic [UserW-1:0] user;
        logic [ChanW-1:0] blocks;
    } t_grant;

endpackage

/* src/ccgs_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccgs_cell
// one user slot: holds the queue length, takes the walk token and the
// remaining channel count from its left neighbor and hands the rest on
// ----------------------------------------------------------------------------
module ccgs_cell
    import ccgs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_active,
    input  logic [UserW-1:0] i_user,
    input  logic [ChanW-1:0] i_weight,
    input  logic             i_wr_en,
    input  logic [QlenW-1:0] i_wr_data,
    input  logic             i_adv,
    input  logic             i_tok,
    input  logic [ChanW-1:0] i_rem,
    output logic             o_tok,
    output logic [ChanW-1:0] o_rem,
    output t_grant           o_grant
);

    logic [QlenW-1:0] r_qlen;
    logic             r_tok;
    logic [ChanW-1:0] r_rem;
    logic [ChanW-1:0] w_qsat;
    logic [ChanW-1:0] w_cap;
    logic [ChanW-1:0] w_blocks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen <= '0;
            r_tok  <= 1'b0;
            r_rem  <= '0;
        end else begin
            if (i_wr_en) begin
                r_qlen <= i_wr_data;
            end
            if (i_adv) begin
                r_tok <= i_tok;
                r_rem <= i_rem;
            end
        end
    end

    always_comb begin
        w_qsat   = (r_qlen > QlenW'({ChanW{1'b1}})) ? {ChanW{1'b1}} : r_qlen[ChanW-1:0];
        w_cap    = (w_qsat < i_weight) ? w_qsat : i_weight;
        w_blocks = '0;
        if (i_active) begin
            w_blocks = (w_cap < r_rem) ? w_cap : r_rem;
        end
        o_tok          = r_tok;
        o_rem          = r_rem - w_blocks;
        o_grant.hit    = r_tok && (w_blocks != '0);
        o_grant.user   = r_tok ? i_user : '0;
        o_grant.blocks = r_tok ? w_blocks : '0;
    end

endmodule

/* src/capped_channel_grant_scheduler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capped_channel_grant_scheduler_top
// capped strict-priority channel grant scheduler
// ----------------------------------------------------------------------------
// A report transfer is taken without holding the input. A tick sends a token
// down a row of MAX_USERS user cells, one cell per cycle unless the output
// stalls a grant, then sends the final grant; the input is held until the
// token walk and the final grant are done.
// Grants leave through one output register, each delayed until the next
// nonzero grant or the end of the walk so that the last one can be marked.
// ----------------------------------------------------------------------------
module capped_channel_grant_scheduler_top
    import ccgs_pkg::*;
#(
    parameter int unsigned MAX_USERS = MaxUsersDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_in                i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output t_out               o_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [CfgW-1:0]    i_cfg_data
);

    logic [ChanW-1:0] r_chan;
    logic [UcntW-1:0] r_ucnt;
    logic [WtabW-1:0] r_wtab;

    logic             r_flush;
    logic             r_pend_vld;
    logic [UserW-1:0] r_pend_user;
    logic [ChanW-1:0] r_pend_blocks;
    logic             r_out_vld;
    t_out             r_out;

    logic             n_flush;
    logic             n_pend_vld;
    logic             n_out_vld;

    logic             w_tok [MAX_USERS+1];
    logic [ChanW-1:0] w_rem [MAX_USERS+1];
    t_grant           w_grant [MAX_USERS];
    t_grant           w_sel;
    logic             w_busy;
    logic             w_out_busy;
    logic             w_adv;
    logic             w_in_acc;
    logic             w_emit_mid;
    logic             w_emit_fin;
    logic             w_walk_end;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= '0;
            r_ucnt <= UcntW'(8);
            r_wtab <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CfgChannelCount: r_chan <= i_cfg_data[ChanW-1:0];
                CfgUserCount:    r_ucnt <= i_cfg_data[UcntW-1:0];
                CfgWeightTable:  r_wtab <= i_cfg_data[WtabW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_busy = r_flush;
        w_sel  = '0;
        for (int i = 0; i < MAX_USERS; i++) begin
            w_busy = w_busy | w_tok[i+1];
            w_sel  = w_sel | w_grant[i];
        end
    end

    assign o_stall    = w_busy;
    assign w_in_acc   = i_valid && !w_busy;
    assign w_out_busy = r_out_vld && i_stall;
    assign w_adv      = !(w_sel.hit && r_pend_vld && w_out_busy);
    assign w_emit_mid = w_adv && w_sel.hit && r_pend_vld;
    assign w_emit_fin = r_flush && r_pend_vld && !w_out_busy;
    assign w_walk_end = w_adv && w_tok[MAX_USERS];

    assign w_tok[0] = w_in_acc && (i_data.req_type == ReqTick);
    assign w_rem[0] = r_chan;

    for (genvar g = 0; g < MAX_USERS; g++) begin : g_cell
        ccgs_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_active  (r_ucnt > UcntW'(g)),
            .i_user    (UserW'(g)),
            .i_weight  (r_wtab[g*ChanW +: ChanW]),
            .i_wr_en   (w_in_acc && (i_data.req_type == ReqReport)
                        && (i_data.user_index == UserW'(g)) && (r_ucnt > UcntW'(g))),
            .i_wr_data (i_data.queue_length),
            .i_adv     (w_adv),
            .i_tok     (w_tok[g]),
            .i_rem     (w_rem[g]),
            .o_tok     (w_tok[g+1]),
            .o_rem     (w_rem[g+1]),
            .o_grant   (w_grant[g])
        );
    end

    always_comb begin
        n_flush = r_flush;
        if (w_walk_end) begin
            n_flush = 1'b1;
        end else if (r_flush && (!r_pend_vld || !w_out_busy)) begin
            n_flush = 1'b0;
        end

        n_pend_vld = r_pend_vld;
        if (w_adv && w_sel.hit) begin
            n_pend_vld = 1'b1;
        end else if (w_emit_fin) begin
            n_pend_vld = 1'b0;
        end

        n_out_vld = r_out_vld;
        if (w_emit_mid || w_emit_fin) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush    <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_flush    <= n_flush;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_sel.hit) begin
            r_pend_user   <= w_sel.user;
            r_pend_blocks <= w_sel.blocks;
        end
        if (w_emit_mid || w_emit_fin) begin
            r_out.grant_user   <= r_pend_user;
            r_out.grant_blocks <= r_pend_blocks;
            r_out.grant_last   <= w_emit_fin;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule
